[hw/rtl/lal_pkg.sv]
package lal_pkg;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [23:0] average_luminance;
        logic [22:0] pixel_total;
        logic        count_overflow;
    } result_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_pix;
        logic lum_step;
        logic log_init;
        logic log_step;
        logic accum;
        logic div_init;
        logic div_step;
        logic exp_init;
        logic exp_step;
        logic finish;
    } lal_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic lum_done;
        logic iter_done;
        logic div_done;
        logic last_pix;
        logic out_busy;
    } lal_sts_t;

    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;
    localparam int          ROOT_MAX = 24;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    typedef logic [31:0] root_tab_t [0:ROOT_MAX];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'h1 << 62;
        rem   = v;
        for (int j = 0; j < 32; j++)
        begin
            if (bit_v > rem)
                bit_v = bit_v >> 2;
        end
        for (int j = 0; j < 32; j++)
        begin
            if (bit_v != 0)
            begin
                if (rem >= res + bit_v)
                begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-i) in Q2.30, each the integer root of the one before
    function automatic root_tab_t root_table();
        root_tab_t   tab;
        logic [63:0] root;
        root   = 64'd2 << 30;
        tab[0] = root[31:0];
        for (int i = 1; i <= ROOT_MAX; i++)
        begin
            root   = isqrt64(root << 30);
            tab[i] = root[31:0];
        end
        return tab;
    endfunction

endpackage

[hw/rtl/log_average_luminance_core.sv]
// Log-average (geometric mean) luminance of a frame of 8.8 RGB pixels. Pixels are taken one
// at a time, through a shared 16x16 multiplier for the three luminance terms and one
// squaring step a cycle for the log2 fraction. After the pixel marked last, a restoring
// divider takes one quotient bit a cycle over the log sum, then the 2^x unit takes one
// fraction bit a cycle. The result sits in an output register, so the next frame may
// start while it waits; a second frame end stalls until it is taken.
module log_average_luminance_core #(
    parameter int MAX_PIXELS    = 4194304,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  lal_pkg::pixel_t  pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output lal_pkg::result_t result
);
    import lal_pkg::*;

    lal_cmd_t cmd;
    lal_sts_t sts;

    lal_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    lal_datapath #(
        .MAX_PIXELS    (MAX_PIXELS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[hw/rtl/lal_ctrl.sv]
module lal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  lal_pkg::lal_sts_t sts,
    output lal_pkg::lal_cmd_t cmd
);
    import lal_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LUM  = 9'b000000010,
        S_LOGI = 9'b000000100,
        S_LOG  = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_DIVI = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_EXP  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign pixel_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = S_LUM;
                end
            end
            S_LUM:
            begin
                cmd.lum_step = 1'b1;
                if (sts.lum_done)
                    state_next = S_LOGI;
            end
            S_LOGI:
            begin
                cmd.log_init = 1'b1;
                state_next   = S_LOG;
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                if (sts.iter_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = sts.last_pix ? S_DIVI : S_IDLE;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                // first cycle here only latches the exponent
                if (!sts.iter_done || !cmd.exp_step)
                    cmd.exp_step = 1'b1;
                if (sts.iter_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_DIV && sts.div_done)
            cmd.exp_init = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/lal_datapath.sv]
module lal_datapath #(
    parameter int MAX_PIXELS    = 4194304,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lal_pkg::pixel_t   pixel,
    input  lal_pkg::lal_cmd_t cmd,
    output lal_pkg::lal_sts_t sts,
    output logic              result_valid,
    input  logic              result_stall,
    output lal_pkg::result_t  result
);
    import lal_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int LOG_W  = LOG_FRAC_BITS + 6;
    localparam int SUM_W  = LOG_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int IDX_W  = $clog2(LOG_FRAC_BITS);
    localparam root_tab_t ROOT_TAB = root_table();

    logic [15:0]               red_reg, green_reg, blue_reg;
    logic                      last_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [33:0]               lum_reg;
    logic [31:0]               z_reg;
    logic [4:0]                p_reg;
    logic [LOG_FRAC_BITS-1:0]  frac_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic                      neg_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [CNT_W:0]            rem_reg;
    logic [SUM_W-1:0]          e_reg;
    logic [31:0]               acc_reg;
    logic                      out_valid_reg;
    logic                      div_fin_reg;
    result_t                   out_reg;

    // luminance term, one channel a cycle
    logic [15:0] chan;
    logic [15:0] coef;
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    begin chan = red_reg;   coef = COEF_R; end
            2'd1:    begin chan = green_reg; coef = COEF_G; end
            default: begin chan = blue_reg;  coef = COEF_B; end
        endcase
    end
    logic [31:0] lum_prod;
    assign lum_prod = chan * coef;

    // log2 normalize
    logic [24:0] x_val;
    logic [4:0]  msb;
    always_comb
    begin
        x_val = 25'(lum_reg >> 8) + 25'd1;
        msb   = '0;
        for (int j = 0; j < 25; j++)
        begin
            if (x_val[j])
                msb = 5'(j);
        end
    end

    logic [63:0] sq;
    logic [32:0] sq_sh;
    assign sq    = 64'(z_reg) * 64'(z_reg);
    assign sq_sh = sq[63:31];

    logic signed [LOG_W-1:0] log_val;
    assign log_val = ((LOG_W'($signed({2'b00, p_reg})) - LOG_W'(16)) <<< LOG_FRAC_BITS)
                     + $signed(LOG_W'(frac_reg));

    logic full;
    assign full = (cnt_reg == CNT_W'(MAX_PIXELS));

    // division
    logic [SUM_W-1:0] mag;
    logic [CNT_W:0]   rem_sh;
    assign mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_sh = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};

    logic signed [SUM_W:0] mean;
    logic signed [SUM_W:0] e_val;
    assign mean  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign e_val = mean + ((SUM_W + 1)'(16) <<< LOG_FRAC_BITS);

    // exponent
    logic [IDX_W-1:0] bit_idx;
    logic [4:0]       root_idx;
    logic [63:0]      ex_prod;
    assign bit_idx  = IDX_W'(LOG_FRAC_BITS - 1) - IDX_W'(step_reg);
    assign root_idx = 5'(step_reg) + 5'd1;
    assign ex_prod  = 64'(acc_reg) * 64'(ROOT_TAB[root_idx]);

    logic [SUM_W-1:0] k_val;
    logic [56:0]      shifted;
    logic [26:0]      rounded;
    logic [23:0]      lum_out;
    assign k_val   = e_reg >> LOG_FRAC_BITS;
    assign shifted = (57'(acc_reg) << k_val[4:0]) + (57'd1 << 29);
    assign rounded = shifted[56:30];
    assign lum_out = (k_val > SUM_W'(24) || rounded > 27'hFF_FFFF) ? 24'hFF_FFFF
                                                                   : rounded[23:0];

    always_comb
    begin
        sts.lum_done  = (step_reg == STEP_W'(2));
        sts.iter_done = (step_reg == STEP_W'(LOG_FRAC_BITS - 1));
        sts.div_done  = (step_reg == STEP_W'(SUM_W - 1));
        sts.last_pix  = last_reg;
        sts.out_busy  = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            red_reg   <= pixel.red;
            green_reg <= pixel.green;
            blue_reg  <= pixel.blue;
            last_reg  <= pixel.last_pixel;
            lum_reg   <= 34'd128;
        end
        if (cmd.lum_step)
            lum_reg <= lum_reg + 34'(lum_prod);
        if (cmd.log_init)
        begin
            p_reg    <= msb;
            z_reg    <= 32'(x_val) << (5'd31 - msb);
            frac_reg <= '0;
        end
        if (cmd.log_step)
        begin
            frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_sh[32]};
            z_reg    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        end
        if (cmd.div_init)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? mag + SUM_W'(cnt_reg) - SUM_W'(1) : mag;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_sh >= (CNT_W + 1)'(cnt_reg))
            begin
                rem_reg <= rem_sh - (CNT_W + 1)'(cnt_reg);
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.exp_init)
            acc_reg <= Q30_ONE;
        // the exponent is still being latched while div_fin_reg is high
        if (cmd.exp_step && !div_fin_reg && e_reg[bit_idx])
            acc_reg <= ex_prod[61:30];
        if (cmd.finish)
        begin
            out_reg.average_luminance <= lum_out;
            out_reg.pixel_total       <= 23'(cnt_reg);
            out_reg.count_overflow    <= ovf_reg;
        end
    end

    // latch the exponent once the quotient is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_fin_reg <= 1'b0;
        else
            div_fin_reg <= cmd.exp_init;
    end
    always_ff @(posedge clk)
    begin
        if (div_fin_reg)
            e_reg <= e_val[SUM_W] ? '0 : e_val[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_pix || cmd.log_init || cmd.div_init || cmd.exp_init
                || div_fin_reg || cmd.accum)
                step_reg <= '0;
            else if (cmd.lum_step || cmd.log_step || cmd.div_step || cmd.exp_step)
                step_reg <= step_reg + STEP_W'(1);
            if (cmd.accum)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                begin
                    sum_reg <= sum_reg + SUM_W'(log_val);
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                sum_reg       <= '0;
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[verif/log_average_luminance_core_tb.sv]
`timescale 1ns / 1ps

module log_average_luminance_core_tb;
    import lal_pkg::*;

    localparam int FRAC = 16;
    localparam longint PIX_LIMIT = 4194304;

    class luminance_scoreboard;
        result_t       pending[$];
        longint        frame_log_sum;
        longint        frame_pixels;
        bit            frame_overflow;
        logic [63:0]   exp_roots[1:FRAC];
        int            mismatches;

        function new();
            logic [63:0] r;
            r = 64'd2 << 30;
            for (int i = 1; i <= FRAC; i++)
            begin
                r = int_sqrt(r << 30);
                exp_roots[i] = r;
            end
            frame_log_sum  = 0;
            frame_pixels   = 0;
            frame_overflow = 0;
            mismatches     = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] acc;
            logic [63:0] step;
            acc  = 0;
            step = 64'h1 << 62;
            while (step > v)
                step = step >> 2;
            while (step != 0)
            begin
                if (v >= acc + step)
                begin
                    v   = v - (acc + step);
                    acc = (acc >> 1) + step;
                end
                else
                    acc = acc >> 1;
                step = step >> 2;
            end
            return acc;
        endfunction

        // log2(x) - 16 with FRAC fraction bits
        function longint fixed_log2(logic [31:0] x);
            int          msb;
            logic [63:0] z;
            longint      fr;
            msb = 0;
            while (msb < 31 && (x >> (msb + 1)) != 0)
                msb++;
            z  = 64'(x) << (31 - msb);
            fr = 0;
            for (int i = 0; i < FRAC; i++)
            begin
                z  = (z * z) >> 31;
                fr = fr << 1;
                if (z >= (64'd2 << 31))
                begin
                    z  = z >> 1;
                    fr = fr | 1;
                end
            end
            return longint'(msb - 16) * (longint'(1) << FRAC) + fr;
        endfunction

        function logic [23:0] fixed_exp2(longint e);
            longint      k;
            longint      f;
            logic [63:0] acc;
            logic [63:0] o;
            k   = e >> FRAC;
            f   = e & ((longint'(1) << FRAC) - 1);
            acc = 64'd1 << 30;
            for (int i = 1; i <= FRAC; i++)
                if ((f >> (FRAC - i)) & 1)
                    acc = (acc * exp_roots[i]) >> 30;
            if (k > 24)
                return 24'hFFFFFF;
            o = ((acc << k) + (64'd1 << 29)) >> 30;
            if (o > 64'hFFFFFF)
                o = 64'hFFFFFF;
            return o[23:0];
        endfunction

        function void note_pixel(pixel_t p);
            logic [63:0] y;
            longint      mean;
            longint      e;
            result_t     res;
            y = (64'd13933 * p.red + 64'd46871 * p.green + 64'd4732 * p.blue + 128) >> 8;
            if (frame_pixels < PIX_LIMIT)
            begin
                frame_log_sum += fixed_log2(32'(y + 1));
                frame_pixels++;
            end
            else
                frame_overflow = 1;
            if (!p.last_pixel)
                return;
            // floor division toward minus infinity
            if (frame_log_sum >= 0)
                mean = frame_log_sum / frame_pixels;
            else
                mean = -((-frame_log_sum + frame_pixels - 1) / frame_pixels);
            e = mean + (longint'(16) << FRAC);
            if (e < 0)
                e = 0;
            res.average_luminance = fixed_exp2(e);
            res.pixel_total       = frame_pixels[22:0];
            res.count_overflow    = frame_overflow;
            pending.push_back(res);
            frame_log_sum  = 0;
            frame_pixels   = 0;
            frame_overflow = 0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %0d %0d %0b", got.average_luminance,
                             got.pixel_total, got.count_overflow);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: lum %0d/%0d total %0d/%0d ovf %0b/%0b (exp/act)",
                             want.average_luminance, got.average_luminance,
                             want.pixel_total, got.pixel_total,
                             want.count_overflow, got.count_overflow);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    pixel_valid;
    logic    pixel_stall;
    pixel_t  pixel;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    luminance_scoreboard sb;
    int      pixels_sent;
    int      burst_left;
    int      stall_mode;

    log_average_luminance_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("log_average_luminance_core test failed");
        $finish;
    end

    // receiver: stall density changes now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 1) == 0);
                default: result_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
        pixel_t p;
        int     gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p.red = r;
        p.green = g;
        p.blue = b;
        p.last_pixel = last;
        pixel       <= p;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    function automatic logic [15:0] pick_channel(int mode);
        case (mode)
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 15));
            2:       return 16'd0;
            default: return 16'($urandom_range(16'hF000, 16'hFFFF));
        endcase
    endfunction

    initial
    begin
        int len;
        int mode;
        bit drained;
        clk          = 1'b0;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        result_stall = 1'b0;
        stall_mode   = 0;
        pixels_sent  = 0;
        burst_left   = 0;
        drained      = 1'b0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // walking one across red and blue, walking zero across green, one frame
        for (int i = 0; i < 16; i++)
            send_pixel(16'h1 << i, ~(16'h1 << i), 16'h1 << (15 - i), i == 15);

        while (pixels_sent < 1750)
        begin
            if ($urandom_range(0, 99) < 70)
                len = $urandom_range(1, 12);
            else if ($urandom_range(0, 4) != 0)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(61, 300);
            if (len > 1750 - pixels_sent)
                len = 1750 - pixels_sent;
            mode = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    mode = $urandom_range(0, 3);
                send_pixel(pick_channel(mode), pick_channel(mode), pick_channel(mode),
                           i == len - 1);
            end
            // drain once midway
            if (pixels_sent > 900 && !drained)
            begin
                drained = 1'b1;
                pixel_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending.size() != 0);
            end
        end
        pixel_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("log_average_luminance_core test passed");
        else
            $display("log_average_luminance_core test failed");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/lal_pkg.sv
hw/rtl/lal_ctrl.sv
hw/rtl/lal_datapath.sv
hw/rtl/log_average_luminance_core.sv
verif/log_average_luminance_core_tb.sv
